[hdl/lgcd_pkg.sv]
// ----------------------------------------------------------------------------
// lgcd_pkg
// Shared types, codes and decode functions for the LED grid command
// decompressor.
// ----------------------------------------------------------------------------
package lgcd_pkg;

    localparam int LvlW = 6;
    localparam int OutLvlW = 7;
    localparam int BtnW = 6;

    // controller -> datapath commands
    typedef struct packed {
        logic ld_red;
        logic ld_green;
        logic ld_blue;
        logic ld_count;
        logic ld_pos;
        logic emit;
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic cnt_zero;    // count bits zero after the blue byte
        logic data_zero;   // incoming byte is zero
        logic left_zero;   // no position bytes left in the group
        logic last_write;  // current write is the last of the position byte
        logic out_free;    // output register can take a word this cycle
    } t_dp_stat;

    // stored level: 0 stays 0, anything else gets +2
    function automatic logic [OutLvlW-1:0] f_stored_level(input logic [LvlW-1:0] lv);
        logic [OutLvlW-1:0] res;
        if (lv == '0) begin
            res = '0;
        end else begin
            res = {1'b0, lv} + 7'd2;
        end
        return res;
    endfunction

    // true when bits 6..4 select a row or column pattern
    function automatic logic f_is_line(input logic [6:0] x);
        return x[6:4] == 3'b110;
    endfunction

    // index of the last write caused by position byte x
    function automatic logic [2:0] f_last_idx(input logic [6:0] x);
        logic [2:0] res;
        if (f_is_line(x)) begin
            res = 3'd7;
        end else if (!x[6]) begin
            res = 3'd0;
        end else if (!x[5]) begin
            res = 3'd1;
        end else begin
            res = 3'd3;
        end
        return res;
    endfunction

    // button of write k for position byte x
    function automatic logic [BtnW-1:0] f_button(input logic [6:0] x, input logic [2:0] k);
        logic [BtnW-1:0] m;
        logic [BtnW-1:0] c;
        logic [BtnW-1:0] res;
        m = ~x[5:0];
        c = x[5:0] & (x[2] ? 6'h23 : 6'h03);
        res = x[5:0];
        if (!f_is_line(x)) begin
            unique case (k[1:0])
                2'd0: res = x[5:0];
                2'd1: res = m;
                2'd2: res = (x[5:0] & 6'h1C) | (m & 6'h03);
                default: res = (x[5:0] & 6'h23) | (m & 6'h1C);
            endcase
        end else if (x[3]) begin
            // column: step through rows in bits 4..2
            res = c | {1'b0, k, 2'b00};
        end else begin
            // row: left half then right half, interleaved
            res = {k[0], x[2:0], k[2:1]};
        end
        return res;
    endfunction

endpackage

[hdl/lgcd_ctrl.sv]
// ----------------------------------------------------------------------------
// lgcd_ctrl
// Group parser and write sequencer: tracks which byte of a color group is
// expected and steps through the writes of one position byte.
// ----------------------------------------------------------------------------
module lgcd_ctrl
    import lgcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_msg_start,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [2:0] ST_RED   = 3'd0;
    localparam logic [2:0] ST_GREEN = 3'd1;
    localparam logic [2:0] ST_BLUE  = 3'd2;
    localparam logic [2:0] ST_COUNT = 3'd3;
    localparam logic [2:0] ST_POS   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] eff_state;
    logic       accept;

    assign o_in_ready = (r_state != ST_EMIT);
    assign accept     = i_in_valid && o_in_ready;
    // a message start forces the red byte
    assign eff_state  = i_msg_start ? ST_RED : r_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        if (r_state == ST_EMIT) begin
            if (i_stat.out_free) begin
                o_cmd.emit = 1'b1;
                if (i_stat.last_write) begin
                    n_state = i_stat.left_zero ? ST_RED : ST_POS;
                end
            end
        end else if (accept) begin
            unique case (eff_state)
                ST_GREEN: begin
                    o_cmd.ld_green = 1'b1;
                    n_state        = ST_BLUE;
                end
                ST_BLUE: begin
                    o_cmd.ld_blue = 1'b1;
                    n_state       = i_stat.cnt_zero ? ST_COUNT : ST_POS;
                end
                ST_COUNT: begin
                    o_cmd.ld_count = 1'b1;
                    n_state        = i_stat.data_zero ? ST_RED : ST_POS;
                end
                ST_POS: begin
                    o_cmd.ld_pos = 1'b1;
                    n_state      = ST_EMIT;
                end
                default: begin
                    // red byte, also any unused code
                    o_cmd.ld_red = 1'b1;
                    n_state      = ST_GREEN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RED;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/lgcd_dp.sv]
// ----------------------------------------------------------------------------
// lgcd_dp
// Datapath: held color levels, count bits, remaining positions, the current
// position byte with its write index, and the output word register.
// ----------------------------------------------------------------------------
module lgcd_dp
    import lgcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_data,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [BtnW-1:0]     o_button,
    output logic [OutLvlW-1:0]  o_red,
    output logic [OutLvlW-1:0]  o_green,
    output logic [OutLvlW-1:0]  o_blue,
    output logic                o_last
);

    logic [LvlW-1:0]    r_red;
    logic [LvlW-1:0]    r_green;
    logic [LvlW-1:0]    r_blue;
    logic [2:0]         r_cnt;
    logic [7:0]         r_left;
    logic [6:0]         r_pos;
    logic [2:0]         r_k;
    logic               r_ovalid;
    logic [BtnW-1:0]    r_button;
    logic [OutLvlW-1:0] r_ored;
    logic [OutLvlW-1:0] r_ogreen;
    logic [OutLvlW-1:0] r_oblue;
    logic               r_olast;
    logic [2:0]         n_cnt_blue;

    // count after the blue byte's bit 6 is merged in
    assign n_cnt_blue = r_cnt | {2'b00, i_data[6]};

    assign o_stat.cnt_zero   = (n_cnt_blue == 3'd0);
    assign o_stat.data_zero  = (i_data == 8'd0);
    assign o_stat.left_zero  = (r_left == 8'd0);
    assign o_stat.last_write = (r_k == f_last_idx(r_pos));
    assign o_stat.out_free   = !r_ovalid || i_out_ready;

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= '0;
            r_green <= '0;
            r_blue  <= '0;
            r_cnt   <= '0;
            r_left  <= '0;
        end else begin
            if (i_cmd.ld_red) begin
                r_red  <= i_data[5:0];
                r_cnt  <= {i_data[6], 2'b00};
                r_left <= '0;
            end
            if (i_cmd.ld_green) begin
                r_green <= i_data[5:0];
                r_cnt   <= r_cnt | {1'b0, i_data[6], 1'b0};
            end
            if (i_cmd.ld_blue) begin
                r_blue <= i_data[5:0];
                r_cnt  <= n_cnt_blue;
                r_left <= {5'd0, n_cnt_blue};
            end
            if (i_cmd.ld_count) begin
                r_left <= i_data;
            end
            if (i_cmd.ld_pos) begin
                r_left <= r_left - 8'd1;
            end
        end
    end

    // position byte and write index
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_pos) begin
            r_pos <= i_data[6:0];
            r_k   <= '0;
        end else if (i_cmd.emit) begin
            r_k <= r_k + 3'd1;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_button <= f_button(r_pos, r_k);
            r_ored   <= f_stored_level(r_red);
            r_ogreen <= f_stored_level(r_green);
            r_oblue  <= f_stored_level(r_blue);
            r_olast  <= o_stat.last_write;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_button    = r_button;
    assign o_red       = r_ored;
    assign o_green     = r_ogreen;
    assign o_blue      = r_oblue;
    assign o_last      = r_olast;

endmodule

[hdl/led_grid_command_decompressor.sv]
// Color, count and position bytes are taken one per cycle while tready is high.
// A position byte then holds the input while the write sequencer generates its
// 1, 2, 4 or 8 button words, one word per cycle unless the output stalls.
// Words appear in the cycle after they are generated (registered output).
// Synchronous active-low reset: parser expects a red byte, output empty.
// ----------------------------------------------------------------------------
// led_grid_command_decompressor
// Expands a compressed color-group byte stream into button write words for
// a 64-button LED grid.
// ----------------------------------------------------------------------------
module led_grid_command_decompressor
    import lgcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] message_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [5:0] button, [12:6] red_level,
                                          // [19:13] green_level,
                                          // [26:20] blue_level, [31:27] zero
    output logic        o_m_axis_tlast    // last_of_run
);

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [BtnW-1:0]    button;
    logic [OutLvlW-1:0] red;
    logic [OutLvlW-1:0] green;
    logic [OutLvlW-1:0] blue;

    lgcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_msg_start (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    lgcd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_button    (button),
        .o_red       (red),
        .o_green     (green),
        .o_blue      (blue),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'd0, blue, green, red, button};

endmodule

[hdl/lgcd_checker.sv]
// ----------------------------------------------------------------------------
// lgcd_checker
// Port-level checks for the LED grid command decompressor, bound to the top.
// ----------------------------------------------------------------------------
module lgcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid after reset");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output word changed");

    // stored red level is never 1 or 2 and never above 65
    a_red_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[12:6] != 7'd1 && o_m_axis_tdata[12:6] != 7'd2
            && o_m_axis_tdata[12:6] <= 7'd65)
        else $error("red level out of range");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[31:27] == 5'd0)
        else $error("padding bits nonzero");

endmodule

bind led_grid_command_decompressor lgcd_checker u_lgcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
